// ===== rtl/servo_speed_ramp_to_pwm_duty_core_macros.svh =====
// Assertion helpers for the servo ramp core.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef SERVO_SPEED_RAMP_TO_PWM_DUTY_CORE_MACROS_SVH
`define SERVO_SPEED_RAMP_TO_PWM_DUTY_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SSRPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define SSRPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssrpd_pkg.sv =====
`timescale 1ns / 1ps
package ssrpd_pkg;

	localparam int ANGLE_W  = 17;
	localparam int PULSE_W  = 15;
	localparam int SPEED_W  = 20;
	localparam int DUTY_W   = 10;
	localparam int CFG_W    = 20;
	localparam int IDX_W    = 3;
	localparam int STEP_W   = 15;   // floor((2^20-1)/50) fits in 15 bits

	// x/50 == (x * RECIP50) >> RECIP_SH for every 20-bit x
	localparam int RECIP_W  = 21;
	localparam int RECIP_SH = 26;
	localparam logic [RECIP_W-1:0] RECIP50 = 21'd1342178;

	// shared restoring divider
	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 17;
	localparam int DIV_Q_W   = 15;
	localparam int DIV_CNT_W = 4;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 20'hFFFFF;
	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 10'd1023;
	localparam logic [DIV_D_W-1:0] PERIOD_US = 17'd20000;

	localparam logic signed [ANGLE_W-1:0] RST_MIN_ANGLE = 17'sd0;
	localparam logic signed [ANGLE_W-1:0] RST_MAX_ANGLE = 17'sd46080;
	localparam logic [PULSE_W-1:0] RST_MIN_PULSE = 15'd500;
	localparam logic [PULSE_W-1:0] RST_MAX_PULSE = 15'd2500;
	localparam logic [SPEED_W-1:0] RST_CRUISE    = 20'd25600;
	localparam logic [SPEED_W-1:0] RST_RAMP      = 20'd6400;
	localparam logic [SPEED_W-1:0] RST_FLOOR     = 20'd25600;

	typedef enum logic [IDX_W-1:0] {
		REG_MIN_ANGLE    = 3'd0,
		REG_MAX_ANGLE    = 3'd1,
		REG_MIN_PULSE    = 3'd2,
		REG_MAX_PULSE    = 3'd3,
		REG_CRUISE_SPEED = 3'd4,
		REG_RAMP_RATE    = 3'd5,
		REG_FLOOR_SPEED  = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_SPEED,
		ST_MOVE,
		ST_POS,
		ST_MUL,
		ST_SUM,
		ST_WAIT_SPAN,
		ST_DUTY,
		ST_WAIT_DUTY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;      // latch input payload
		logic recip_ramp;   // step = ramp_rate / 50
		logic speed;        // update speed
		logic recip_speed;  // mv = speed / 50
		logic pos;          // update position
		logic mul;          // pulse interpolation products
		logic div_span;     // start numerator / span
		logic pulse_min;    // span not positive: pulse = min_pulse
		logic pulse_div;    // pulse = divider quotient
		logic div_duty;     // start pulse*1023 / 20000
		logic duty_wr;      // last_duty = saturated quotient
		logic load_out;     // load output register
	} cmd_t;

	typedef struct packed {
		logic en;
		logic span_pos;
		logic div_done;
	} sts_t;

endpackage

// ===== rtl/ssrpd_div.sv =====
`timescale 1ns / 1ps
module ssrpd_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ssrpd_pkg::DIV_N_W-1:0] dividend,
	input  logic [ssrpd_pkg::DIV_D_W-1:0] divisor,
	output logic done,
	output logic [ssrpd_pkg::DIV_Q_W-1:0] quotient
);
	import ssrpd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0]   rem_q;
	logic [DIV_N_W-1:0]   dsh_q;
	logic [DIV_Q_W-1:0]   quo_q;
	logic                 fits;

	// quotient is known to stay below 2^DIV_Q_W, so start with the divisor
	// aligned to the top quotient bit
	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_Q_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {{(DIV_N_W-DIV_D_W-DIV_Q_W+1){1'b0}}, divisor, {(DIV_Q_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
			dsh_q <= {1'b0, dsh_q[DIV_N_W-1:1]};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/ssrpd_dp.sv =====
`timescale 1ns / 1ps
module ssrpd_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ssrpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [ssrpd_pkg::CFG_W-1:0] cfg_data,
	input  logic signed [ssrpd_pkg::ANGLE_W-1:0] goal_angle,
	input  logic enable,
	input  ssrpd_pkg::cmd_t cmd,
	output ssrpd_pkg::sts_t sts,
	output logic [ssrpd_pkg::DUTY_W-1:0] duty,
	output logic signed [ssrpd_pkg::ANGLE_W-1:0] angle_now,
	output logic driven
);
	import ssrpd_pkg::*;

	// configuration
	logic signed [ANGLE_W-1:0] min_angle_q, max_angle_q;
	logic [PULSE_W-1:0]        min_pulse_q, max_pulse_q;
	logic [SPEED_W-1:0]        cruise_q, ramp_q, floor_q;

	// state
	logic signed [ANGLE_W-1:0] position_q;
	logic [SPEED_W-1:0]        speed_q;
	logic [DUTY_W-1:0]         last_duty_q;

	// working registers
	logic signed [ANGLE_W-1:0] goal_q;
	logic                      en_q;
	logic [STEP_W-1:0]         recip_q;
	logic signed [ANGLE_W:0]   diff_q;
	logic [DIV_N_W-1:0]        prod_a_q;
	logic signed [33:0]        prod_b_q;
	logic                      span_pos_q;
	logic [PULSE_W-1:0]        pulse_q;

	// output register
	logic [DUTY_W-1:0]         duty_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic                      driven_q;

	// /50 by reciprocal, one multiplier shared by ramp_rate and speed
	logic [SPEED_W-1:0]         recip_in;
	logic [SPEED_W+RECIP_W-1:0] recip_prod;

	assign recip_in   = cmd.recip_speed ? speed_q : ramp_q;
	assign recip_prod = {{RECIP_W{1'b0}}, recip_in} * {{SPEED_W{1'b0}}, RECIP50};

	// speed ramp
	logic [SPEED_W:0]   sp_sum;
	logic [SPEED_W-1:0] sp_step, sp_ramp, sp_next;

	assign sp_step = {{(SPEED_W-STEP_W){1'b0}}, recip_q};
	assign sp_sum  = {1'b0, speed_q} + {1'b0, sp_step};

	always_comb begin
		if (speed_q < cruise_q) begin
			sp_ramp = sp_sum[SPEED_W] ? SPEED_MAX : sp_sum[SPEED_W-1:0];
		end else if (speed_q > cruise_q) begin
			sp_ramp = (sp_step > speed_q) ? '0 : speed_q - sp_step;
		end else begin
			sp_ramp = speed_q;
		end
		sp_next = (sp_ramp < floor_q) ? floor_q : sp_ramp;
	end

	// position move and clamp
	logic [ANGLE_W:0]          dist_abs;
	logic [ANGLE_W:0]          mv_ext, mv_lim;
	logic signed [ANGLE_W+1:0] pos_ext, mv_s, pos_mv, pos_lo, pos_hi;
	logic signed [ANGLE_W+1:0] min_ext, max_ext;
	logic                      moving_up;

	assign dist_abs  = diff_q[ANGLE_W] ? (ANGLE_W+1)'(-diff_q) : diff_q;
	assign mv_ext    = {{(ANGLE_W+1-STEP_W){1'b0}}, recip_q};
	assign mv_lim    = (mv_ext > dist_abs) ? dist_abs : mv_ext;
	assign moving_up = !diff_q[ANGLE_W] && (diff_q != '0);
	assign pos_ext   = {{2{position_q[ANGLE_W-1]}}, position_q};
	assign min_ext   = {{2{min_angle_q[ANGLE_W-1]}}, min_angle_q};
	assign max_ext   = {{2{max_angle_q[ANGLE_W-1]}}, max_angle_q};
	assign mv_s      = $signed({1'b0, mv_lim});
	assign pos_mv    = moving_up ? pos_ext + mv_s : pos_ext - mv_s;
	assign pos_lo    = (pos_mv < min_ext) ? min_ext : pos_mv;
	assign pos_hi    = (pos_lo > max_ext) ? max_ext : pos_lo;

	// pulse interpolation: min_pulse*span + (pos-min)*(max_pulse-min_pulse)
	logic signed [ANGLE_W:0]   span, offs;
	logic signed [PULSE_W:0]   dpulse;
	logic signed [33:0]        prod_b;
	logic signed [34:0]        num_s;
	logic [DIV_N_W-1:0]        num_u;

	assign span   = {max_angle_q[ANGLE_W-1], max_angle_q} - {min_angle_q[ANGLE_W-1], min_angle_q};
	assign offs   = {position_q[ANGLE_W-1], position_q} - {min_angle_q[ANGLE_W-1], min_angle_q};
	assign dpulse = $signed({1'b0, max_pulse_q}) - $signed({1'b0, min_pulse_q});
	assign prod_b = offs * dpulse;
	assign num_s  = $signed({3'b000, prod_a_q}) + $signed({prod_b_q[33], prod_b_q});
	assign num_u  = num_s[34] ? '0 : num_s[DIV_N_W-1:0];

	// pulse * 1023 as a shift and subtract
	logic [PULSE_W+DUTY_W-1:0] duty_num;

	assign duty_num = {pulse_q, {DUTY_W{1'b0}}} - {{DUTY_W{1'b0}}, pulse_q};

	// shared divider
	logic                 div_start, div_done;
	logic [DIV_N_W-1:0]   div_n;
	logic [DIV_D_W-1:0]   div_d;
	logic [DIV_Q_W-1:0]   div_q;

	assign div_start = cmd.div_span || cmd.div_duty;
	assign div_n     = cmd.div_span ? num_u
	                                : {{(DIV_N_W-PULSE_W-DUTY_W){1'b0}}, duty_num};
	assign div_d     = cmd.div_span ? span[DIV_D_W-1:0] : PERIOD_US;

	ssrpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q <= RST_MIN_ANGLE;
			max_angle_q <= RST_MAX_ANGLE;
			min_pulse_q <= RST_MIN_PULSE;
			max_pulse_q <= RST_MAX_PULSE;
			cruise_q    <= RST_CRUISE;
			ramp_q      <= RST_RAMP;
			floor_q     <= RST_FLOOR;
			position_q  <= '0;
			speed_q     <= '0;
			last_duty_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_ANGLE:    min_angle_q <= cfg_data[ANGLE_W-1:0];
					REG_MAX_ANGLE:    max_angle_q <= cfg_data[ANGLE_W-1:0];
					REG_MIN_PULSE:    min_pulse_q <= cfg_data[PULSE_W-1:0];
					REG_MAX_PULSE:    max_pulse_q <= cfg_data[PULSE_W-1:0];
					REG_CRUISE_SPEED: cruise_q    <= cfg_data[SPEED_W-1:0];
					REG_RAMP_RATE:    ramp_q      <= cfg_data[SPEED_W-1:0];
					REG_FLOOR_SPEED:  floor_q     <= cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (cmd.speed) begin
				speed_q <= sp_next;
			end
			if (cmd.pos) begin
				position_q <= pos_hi[ANGLE_W-1:0];
			end
			if (cmd.duty_wr) begin
				last_duty_q <= (div_q > {{(DIV_Q_W-DUTY_W){1'b0}}, DUTY_MAX})
				               ? DUTY_MAX : div_q[DUTY_W-1:0];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			goal_q <= goal_angle;
			en_q   <= enable;
		end
		if (cmd.recip_ramp) begin
			recip_q <= recip_prod[RECIP_SH +: STEP_W];
			diff_q  <= {goal_q[ANGLE_W-1], goal_q} - {position_q[ANGLE_W-1], position_q};
		end
		if (cmd.recip_speed) begin
			recip_q <= recip_prod[RECIP_SH +: STEP_W];
		end
		if (cmd.mul) begin
			prod_a_q   <= {{(DIV_N_W-PULSE_W){1'b0}}, min_pulse_q}
			            * {{(DIV_N_W-DIV_D_W){1'b0}}, span[DIV_D_W-1:0]};
			prod_b_q   <= prod_b;
			span_pos_q <= !span[ANGLE_W] && (span != '0);
		end
		if (cmd.pulse_min) begin
			pulse_q <= min_pulse_q;
		end
		if (cmd.pulse_div) begin
			pulse_q <= div_q;
		end
		if (cmd.load_out) begin
			duty_q   <= last_duty_q;
			angle_q  <= position_q;
			driven_q <= en_q;
		end
	end

	assign sts.en       = en_q;
	assign sts.span_pos = span_pos_q;
	assign sts.div_done = div_done;

	assign duty      = duty_q;
	assign angle_now = angle_q;
	assign driven    = driven_q;

endmodule

// ===== rtl/ssrpd_ctrl.sv =====
`timescale 1ns / 1ps
module ssrpd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  ssrpd_pkg::sts_t sts,
	output ssrpd_pkg::cmd_t cmd
);
	import ssrpd_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.recip_ramp = 1'b1;
				state_d        = sts.en ? ST_SPEED : ST_DONE;
			end
			ST_SPEED: begin
				cmd.speed = 1'b1;
				state_d   = ST_MOVE;
			end
			ST_MOVE: begin
				cmd.recip_speed = 1'b1;
				state_d         = ST_POS;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (sts.span_pos) begin
					cmd.div_span = 1'b1;
					state_d      = ST_WAIT_SPAN;
				end else begin
					cmd.pulse_min = 1'b1;
					state_d       = ST_DUTY;
				end
			end
			ST_WAIT_SPAN: begin
				if (sts.div_done) begin
					cmd.pulse_div = 1'b1;
					state_d       = ST_DUTY;
				end
			end
			ST_DUTY: begin
				cmd.div_duty = 1'b1;
				state_d      = ST_WAIT_DUTY;
			end
			ST_WAIT_DUTY: begin
				if (sts.div_done) begin
					cmd.duty_wr = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/servo_speed_ramp_to_pwm_duty_core.sv =====
// Sequencing: an enabled tick runs every step below (no span division when the degree
//   span is not positive); a disabled tick skips to the output transfer. The two 15-step
//   divisions dominate. The shared divider and the sequencer handle one tick at a time.
//   A held result does not block the next input transfer.
// Reset (arst_n low, async): registers return to their reset values, position, speed
//   and last duty clear, the output register empties.
`timescale 1ns / 1ps
`include "servo_speed_ramp_to_pwm_duty_core_macros.svh"
module servo_speed_ramp_to_pwm_duty_core (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic cfg_we,
	input  logic [ssrpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [ssrpd_pkg::CFG_W-1:0] cfg_data,
	// tick input
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [ssrpd_pkg::ANGLE_W-1:0] goal_angle,
	input  logic enable,
	// result output
	output logic out_valid,
	input  logic out_ready,
	output logic [ssrpd_pkg::DUTY_W-1:0] duty,
	output logic signed [ssrpd_pkg::ANGLE_W-1:0] angle_now,
	output logic driven
);
	import ssrpd_pkg::*;

	// Sequencer drives one-hot-ish command strobes per step; the datapath
	// holds config, servo state, the /50 reciprocal multiplier, the pulse
	// interpolation products and the shared restoring divider.
	cmd_t cmd;
	sts_t sts;

	ssrpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Step order for an enabled tick:
	//   ramp_rate/50 and goal distance, speed ramp + floor, speed/50,
	//   move + clamp, interpolation products, numerator / span,
	//   pulse*1023 / 20000 with saturation, then output transfer.
	ssrpd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.goal_angle (goal_angle),
		.enable     (enable),
		.cmd        (cmd),
		.sts        (sts),
		.duty       (duty),
		.angle_now  (angle_now),
		.driven     (driven)
	);

	// a transfer in always leaves the sequencer busy in the next cycle
	`SSRPD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input taken while busy")
	// never overwrite a result that has not been transferred
	`SSRPD_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "result overwritten")
	// span division only with a positive span
	`SSRPD_ASSERT_SAME(a_span_pos, cmd.div_span, sts.span_pos, "division by non-positive span")
	// duty state only changes on enabled ticks
	`SSRPD_ASSERT_SAME(a_duty_en, cmd.duty_wr, sts.en, "duty updated on disabled tick")

endmodule
